[rtl/irfe_pkg.sv]
// ----------------------------------------------------------------------------
// irfe_pkg
// shared constants, codes and helpers of the image rotate / flip engine
// ----------------------------------------------------------------------------
package irfe_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 9;
  localparam int MODE_W = 3;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 9;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int SRC_W  = DIM_W + 1;
  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT_RIGHT  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_LEFT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIRROR_COL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR_ROW = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_INVERT = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAXVAL = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd4;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[rtl/irfe_frame_ram.sv]
// ----------------------------------------------------------------------------
// irfe_frame_ram
// single-port synchronous frame store with a registered read
// ----------------------------------------------------------------------------
module irfe_frame_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/image_rotate_flip_engine.sv]
// ----------------------------------------------------------------------------
// image_rotate_flip_engine
// loads a grayscale frame in raster order and reads it back rotated,
// mirrored or unchanged, with optional inversion
// ----------------------------------------------------------------------------
// The block takes one command per clock and never raises busy. A load beat
// writes its pixel into the single-port frame store in the cycle it is taken,
// unless the frame is full, and gives no result. A read beat gives exactly one
// result, on the cycle after it is taken, marked by out_valid for one cycle: the
// frame store read is registered, so results trail their reads while reads follow
// each other back to back. The receiver cannot stall, so it must take every result
// in the cycle it appears. A read before the frame is full returns read_status set
// with pixel and last flag at zero. After the beat flagged last_pixel the block
// expects a new frame. The frame store is not cleared after reset; the user must
// see that each pixel read back was loaded first, as the block does not check it.
// ----------------------------------------------------------------------------
module image_rotate_flip_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [irfe_pkg::PIX_W-1:0]    in_pixel_in,
  output logic                          out_valid,
  output logic [irfe_pkg::PIX_W-1:0]    out_pixel_out,
  output logic                          out_last_pixel,
  output logic                          out_read_status,
  input  logic                          cfg_we,
  input  logic [irfe_pkg::IDX_W-1:0]    cfg_index,
  input  logic [irfe_pkg::CFG_W-1:0]    cfg_data
);

  localparam int PIX_W  = irfe_pkg::PIX_W;
  localparam int DIM_W  = irfe_pkg::DIM_W;
  localparam int MODE_W = irfe_pkg::MODE_W;
  localparam int COL_W  = irfe_pkg::COL_W;
  localparam int ROW_W  = irfe_pkg::ROW_W;
  localparam int CNT_W  = irfe_pkg::CNT_W;
  localparam int SRC_W  = irfe_pkg::SRC_W;
  localparam int ADDR_W = irfe_pkg::ADDR_W;

  // configuration
  logic [MODE_W-1:0] mode_r;
  logic              inv_r;
  logic [PIX_W-1:0]  maxv_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;

  // frame counters
  logic [ROW_W-1:0]  load_row_r;
  logic [COL_W-1:0]  load_col_r;
  logic              full_r;
  logic [CNT_W-1:0]  out_row_r;
  logic [CNT_W-1:0]  out_col_r;

  // result stage
  logic              out_valid_r;
  logic              err_r;
  logic              last_r;
  logic              oob_r;
  logic              inv_q_r;
  logic [PIX_W-1:0]  maxv_q_r;

  logic              acc_load;
  logic              acc_read;
  logic [DIM_W-1:0]  w_c;
  logic [DIM_W-1:0]  h_c;
  logic              rot;
  logic [DIM_W-1:0]  ow;
  logic [DIM_W-1:0]  oh;
  logic [SRC_W-1:0]  r_x;
  logic [SRC_W-1:0]  c_x;
  logic [SRC_W-1:0]  wm1;
  logic [SRC_W-1:0]  hm1;
  logic [SRC_W-1:0]  sr_x;
  logic [SRC_W-1:0]  sc_x;
  logic              src_oob;
  logic              col_end;
  logic              row_end;
  logic              ld_col_end;
  logic              ld_row_end;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_en;
  logic              ram_we;
  logic [PIX_W-1:0]  ram_q;
  logic [PIX_W-1:0]  src_pix;
  logic [PIX_W-1:0]  res_pix;

  assign busy     = 1'b0;
  assign acc_load = start && !busy && (in_command == irfe_pkg::CMD_LOAD);
  assign acc_read = start && !busy && (in_command == irfe_pkg::CMD_READ);

  assign w_c = irfe_pkg::clamp_dim(width_r, DIM_W'(irfe_pkg::MAX_WIDTH));
  assign h_c = irfe_pkg::clamp_dim(height_r, DIM_W'(irfe_pkg::MAX_HEIGHT));
  assign rot = (mode_r == irfe_pkg::MODE_ROT_RIGHT) || (mode_r == irfe_pkg::MODE_ROT_LEFT);
  assign ow  = rot ? h_c : w_c;
  assign oh  = rot ? w_c : h_c;

  assign r_x = SRC_W'(out_row_r);
  assign c_x = SRC_W'(out_col_r);
  assign wm1 = SRC_W'(w_c) - SRC_W'(1);
  assign hm1 = SRC_W'(h_c) - SRC_W'(1);

  always_comb begin
    case (mode_r)
      irfe_pkg::MODE_ROT_RIGHT: begin
        sr_x = hm1 - c_x;
        sc_x = r_x;
      end
      irfe_pkg::MODE_ROT_LEFT: begin
        sr_x = c_x;
        sc_x = wm1 - r_x;
      end
      irfe_pkg::MODE_MIRROR_COL: begin
        sr_x = r_x;
        sc_x = wm1 - c_x;
      end
      irfe_pkg::MODE_MIRROR_ROW: begin
        sr_x = hm1 - r_x;
        sc_x = c_x;
      end
      default: begin
        sr_x = r_x;
        sc_x = c_x;
      end
    endcase
  end

  // underflow wraps high and lands outside the store
  assign src_oob = (sr_x >= SRC_W'(irfe_pkg::MAX_HEIGHT)) ||
                   (sc_x >= SRC_W'(irfe_pkg::MAX_WIDTH));

  assign col_end    = (c_x + SRC_W'(1)) >= SRC_W'(ow);
  assign row_end    = (r_x + SRC_W'(1)) >= SRC_W'(oh);
  assign ld_col_end = (SRC_W'(load_col_r) + SRC_W'(1)) >= SRC_W'(w_c);
  assign ld_row_end = (SRC_W'(load_row_r) + SRC_W'(1)) >= SRC_W'(h_c);

  assign rd_addr = ADDR_W'(sr_x[ROW_W-1:0]) * ADDR_W'(irfe_pkg::MAX_WIDTH) +
                   ADDR_W'(sc_x[COL_W-1:0]);
  assign wr_addr = ADDR_W'(load_row_r) * ADDR_W'(irfe_pkg::MAX_WIDTH) +
                   ADDR_W'(load_col_r);

  assign ram_we   = acc_load && !full_r;
  assign ram_en   = ram_we || (acc_read && full_r);
  assign ram_addr = ram_we ? wr_addr : rd_addr;

  irfe_frame_ram #(
    .DATA_W (PIX_W),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_pixel_in),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= irfe_pkg::MODE_NONE;
      inv_r       <= 1'b0;
      maxv_r      <= '1;
      width_r     <= irfe_pkg::DIM_RESET;
      height_r    <= irfe_pkg::DIM_RESET;
      load_row_r  <= '0;
      load_col_r  <= '0;
      full_r      <= 1'b0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          irfe_pkg::REG_MODE: begin
            mode_r <= (cfg_data[MODE_W-1:0] > irfe_pkg::MODE_MIRROR_ROW) ?
                      irfe_pkg::MODE_NONE : cfg_data[MODE_W-1:0];
          end
          irfe_pkg::REG_INVERT: inv_r    <= cfg_data[0];
          irfe_pkg::REG_MAXVAL: maxv_r   <= cfg_data[PIX_W-1:0];
          irfe_pkg::REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
          irfe_pkg::REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end

      out_valid_r <= acc_read;
      if (acc_read) begin
        err_r  <= !full_r;
        last_r <= full_r && col_end && row_end;
      end

      if (ram_we) begin
        if (ld_col_end) begin
          load_col_r <= '0;
          if (ld_row_end) begin
            load_row_r <= '0;
            full_r     <= 1'b1;
          end else begin
            load_row_r <= load_row_r + ROW_W'(1);
          end
        end else begin
          load_col_r <= load_col_r + COL_W'(1);
        end
      end

      if (acc_read && full_r) begin
        if (col_end) begin
          out_col_r <= '0;
          if (row_end) begin
            out_row_r  <= '0;
            full_r     <= 1'b0;
            load_row_r <= '0;
            load_col_r <= '0;
          end else begin
            out_row_r <= out_row_r + CNT_W'(1);
          end
        end else begin
          out_col_r <= out_col_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_read) begin
      oob_r    <= src_oob;
      inv_q_r  <= inv_r;
      maxv_q_r <= maxv_r;
    end
  end

  assign src_pix = oob_r ? '0 : ram_q;
  assign res_pix = inv_q_r ? (maxv_q_r - src_pix) : src_pix;

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = err_r ? '0 : res_pix;
  assign out_last_pixel  = last_r;
  assign out_read_status = err_r;

  a_result_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_read))
    else $error("result beat without a read");

  a_full_load_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_load && full_r && !acc_read) |=> $stable(load_row_r) && $stable(load_col_r))
    else $error("load counters moved while frame full");

  a_last_clears_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_pixel) |-> !full_r)
    else $error("frame still full after last pixel");

  a_error_beat_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_status) |-> (out_pixel_out == '0) && !out_last_pixel)
    else $error("error beat carries pixel data");

  a_read_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (out_row_r == '0) && (out_col_r == '0))
    else $error("output counters moved without a full frame");

endmodule

[tb/image_rotate_flip_engine_tb.sv]
// ----------------------------------------------------------------------------
// image_rotate_flip_engine_tb
// self-checking bench for the frame rotate / mirror / invert engine
// ----------------------------------------------------------------------------
// An 8 x 8 frame is loaded first and read back inverted, so that every frame
// store entry that later frames can reach holds a known value. A short
// directed run then covers extreme pixels, rotation with a zero max value,
// unused mode and register codes, a zero size, loads while full, reads before
// full and a size change part way through a frame. A frame with a width above
// the maximum and a zero height follows. Random frames of up to 8 x 8 pixels,
// with random settings and a little noise, close the run. A scoreboard keeps
// its own copy of the frame store and counters, predicts every read beat and
// checks each result in order.
// ----------------------------------------------------------------------------
module image_rotate_flip_engine_tb;
  import irfe_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int unsigned      RANDOM_BEATS    = 260;
  localparam int unsigned      PREFILL_DIM     = 8;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             status;
  } pixel_result_t;

  class frame_scoreboard;
    bit [PIX_W-1:0]  store [MAX_WIDTH*MAX_HEIGHT];
    int unsigned     load_row, load_col, out_row, out_col;
    bit              full;
    logic [MODE_W-1:0] mode;
    logic            invert;
    logic [PIX_W-1:0] max_val;
    logic [DIM_W-1:0] width, height;
    pixel_result_t   due_pixels [$];
    int unsigned     beats, loads, reads, early_reads, frames, reg_writes;
    int unsigned     results, mismatches;

    function new();
      mode    = MODE_NONE;
      invert  = 1'b0;
      max_val = 8'd255;
      width   = DIM_W'(256);
      height  = DIM_W'(256);
    endfunction

    function int unsigned dim_used(logic [DIM_W-1:0] v, int unsigned limit);
      if (v == '0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_MODE:   mode = data[MODE_W-1:0];
        REG_INVERT: invert = data[0];
        REG_MAXVAL: max_val = data[PIX_W-1:0];
        REG_WIDTH:  width = data[DIM_W-1:0];
        REG_HEIGHT: height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted beat: load into the store or predict the pixel read out
    function void note_beat(logic cmd, logic [PIX_W-1:0] pix);
      int unsigned   w, h, ow, oh, r, c, sr, sc;
      logic [MODE_W-1:0] m;
      logic [PIX_W-1:0] val;
      bit            rot;
      pixel_result_t exp;
      w = dim_used(width, MAX_WIDTH);
      h = dim_used(height, MAX_HEIGHT);
      m = (mode > MODE_MIRROR_ROW) ? MODE_NONE : mode;
      if (cmd == CMD_LOAD) begin
        if (full) return;
        beats++;
        loads++;
        if (load_row < MAX_HEIGHT && load_col < MAX_WIDTH)
          store[load_row*MAX_WIDTH + load_col] = pix;
        if (load_col + 1 >= w) begin
          load_col = 0;
          if (load_row + 1 >= h) begin
            load_row = 0;
            full = 1'b1;
          end else begin
            load_row++;
          end
        end else begin
          load_col++;
        end
        return;
      end
      beats++;
      reads++;
      if (!full) begin
        early_reads++;
        exp = '{pixel: '0, last: 1'b0, status: 1'b1};
        due_pixels.push_back(exp);
        return;
      end
      rot = (m == MODE_ROT_RIGHT) || (m == MODE_ROT_LEFT);
      ow = rot ? h : w;
      oh = rot ? w : h;
      r = out_row;
      c = out_col;
      case (m)
        MODE_ROT_RIGHT: begin
          sr = (h - 1) - c;
          sc = r;
        end
        MODE_ROT_LEFT: begin
          sr = c;
          sc = (w - 1) - r;
        end
        MODE_MIRROR_COL: begin
          sr = r;
          sc = (w - 1) - c;
        end
        MODE_MIRROR_ROW: begin
          sr = (h - 1) - r;
          sc = c;
        end
        default: begin
          sr = r;
          sc = c;
        end
      endcase
      // wrapped coordinates fall outside the store and read as zero
      val = (sr < MAX_HEIGHT && sc < MAX_WIDTH) ? store[sr*MAX_WIDTH + sc] : '0;
      if (invert) val = max_val - val;
      exp = '{pixel: val, last: 1'b0, status: 1'b0};
      if (c + 1 >= ow) begin
        out_col = 0;
        if (r + 1 >= oh) begin
          out_row  = 0;
          exp.last = 1'b1;
          full     = 1'b0;
          load_row = 0;
          load_col = 0;
        end else begin
          out_row++;
        end
      end else begin
        out_col++;
      end
      due_pixels.push_back(exp);
    endfunction

    function void check_pixel(pixel_result_t got);
      pixel_result_t exp;
      results++;
      if (got.last === 1'b1) frames++;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected beat, pixel %0d last %b status %b",
                   results, got.pixel, got.last, got.status);
        return;
      end
      exp = due_pixels.pop_front();
      if (got.pixel !== exp.pixel || got.last !== exp.last || got.status !== exp.status)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected pixel %0d last %b status %b, got %0d %b %b",
                   results, exp.pixel, exp.last, exp.status,
                   got.pixel, got.last, got.status);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_command;
  logic [PIX_W-1:0]  in_pixel_in;
  logic              out_valid;
  logic [PIX_W-1:0]  out_pixel_out;
  logic              out_last_pixel;
  logic              out_read_status;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  frame_scoreboard   sb;
  bit                gaps_on;

  image_rotate_flip_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_pixel_out   (out_pixel_out),
    .out_last_pixel  (out_last_pixel),
    .out_read_status (out_read_status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && busy === 1'b0) sb.note_beat(in_command, in_pixel_in);
      if (out_valid !== 1'b0)
        sb.check_pixel(pixel_result_t'({out_pixel_out, out_last_pixel, out_read_status}));
    end
  end

  // driver tasks are entered and left at a falling edge
  task automatic issue(input logic cmd, input logic [PIX_W-1:0] pix);
    start       <= 1'b1;
    in_command  <= cmd;
    in_pixel_in <= pix;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause(input int unsigned long_max);
    int unsigned r, n;
    r = $urandom_range(0, 99);
    n = 0;
    if (gaps_on && r >= 60) n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, long_max);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.due_pixels.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reshape();
    int unsigned r;
    r = $urandom_range(0, 2);
    if (r == 0) cfg_write(REG_WIDTH, CFG_W'($urandom_range(0, 4)));
    else if (r == 1) cfg_write(REG_HEIGHT, CFG_W'($urandom_range(0, 4)));
    else cfg_write(REG_MODE, CFG_W'($urandom));
  endtask

  // sizes stay within the prefilled corner of the store
  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 30) return CFG_W'($urandom_range(5, PREFILL_DIM));
    return CFG_W'($urandom_range(1, 4));
  endfunction

  task automatic random_frame();
    int unsigned      r, guard;
    logic [CFG_W-1:0] wv, hv;
    gaps_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 1)) cfg_write(REG_MODE, CFG_W'($urandom));
    if ($urandom_range(0, 2) == 0) cfg_write(REG_INVERT, CFG_W'($urandom));
    if ($urandom_range(0, 2) == 0) begin
      r = $urandom_range(0, 3);
      cfg_write(REG_MAXVAL, (r == 0) ? '0 : (r == 1) ? '1 : CFG_W'($urandom));
    end
    if ($urandom_range(0, 9) == 0)
      cfg_write(IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), CFG_W'($urandom));
    wv = pick_dim();
    hv = pick_dim();
    cfg_write(REG_WIDTH, wv);
    cfg_write(REG_HEIGHT, hv);
    guard = 0;
    while (!sb.full && guard < 1200) begin
      guard++;
      r = $urandom_range(0, 99);
      if (r < 2) reshape();
      else if (r < 6) issue(CMD_READ, PIX_W'($urandom));
      else issue(CMD_LOAD, PIX_W'($urandom));
      pause(40);
    end
    guard = 0;
    while (sb.full && guard < 1200) begin
      guard++;
      r = $urandom_range(0, 99);
      if (r < 2) reshape();
      else if (r < 5) issue(CMD_LOAD, PIX_W'($urandom));
      else issue(CMD_READ, PIX_W'($urandom));
      pause(40);
    end
  endtask

  initial begin
    int unsigned target;
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_command  = CMD_LOAD;
    in_pixel_in = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_MODE;
    cfg_data    = '0;
    gaps_on     = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // small frame fills the corner that later frames reach, read back inverted
    issue(CMD_READ, '1);
    cfg_write(REG_INVERT, CFG_W'(1));
    cfg_write(REG_WIDTH, CFG_W'(PREFILL_DIM));
    cfg_write(REG_HEIGHT, CFG_W'(PREFILL_DIM));
    repeat (PREFILL_DIM * PREFILL_DIM) begin
      issue(CMD_LOAD, PIX_W'($urandom));
      pause(8);
    end
    while (sb.full) begin
      issue(CMD_READ, PIX_W'($urandom));
      pause(8);
    end

    // 3 x 2 rotated right, inverted against zero max value
    cfg_write(REG_WIDTH, CFG_W'(3));
    cfg_write(REG_HEIGHT, CFG_W'(2));
    cfg_write(REG_MODE, CFG_W'(MODE_ROT_RIGHT));
    cfg_write(REG_MAXVAL, 9'h100);
    cfg_write(REG_SPARE_FIRST, '1);
    cfg_write(REG_SPARE_LAST, '1);
    issue(CMD_READ, '1);
    issue(CMD_LOAD, 8'h00);
    issue(CMD_LOAD, 8'hff);
    issue(CMD_LOAD, 8'h5a);
    issue(CMD_LOAD, 8'ha5);
    issue(CMD_LOAD, 8'h01);
    issue(CMD_LOAD, 8'h80);
    issue(CMD_LOAD, 8'h4d);
    repeat (6) issue(CMD_READ, '0);

    // unused mode, zero width, height shrunk part way through the load
    cfg_write(REG_MODE, CFG_W'(7));
    cfg_write(REG_INVERT, '0);
    cfg_write(REG_WIDTH, '0);
    cfg_write(REG_HEIGHT, CFG_W'(3));
    issue(CMD_LOAD, 8'h11);
    issue(CMD_LOAD, 8'h22);
    cfg_write(REG_HEIGHT, CFG_W'(2));
    issue(CMD_LOAD, 8'h33);
    repeat (3) issue(CMD_READ, '1);

    // width above the maximum, zero height, mirrored columns
    cfg_write(REG_MODE, CFG_W'(MODE_MIRROR_COL));
    cfg_write(REG_WIDTH, CFG_W'(300));
    cfg_write(REG_HEIGHT, '0);
    repeat (MAX_WIDTH) begin
      issue(CMD_LOAD, PIX_W'($urandom));
      pause(8);
    end
    while (sb.full) begin
      issue(CMD_READ, PIX_W'($urandom));
      pause(8);
    end

    target = sb.beats + RANDOM_BEATS;
    while (sb.beats < target) random_frame();

    settle();
    $display("covered %0d loads and %0d reads (%0d before a full frame), %0d frames out",
             sb.loads, sb.reads, sb.early_reads, sb.frames);
    $display("%0d register writes, %0d results checked, %0d mismatches, %0d outstanding",
             sb.reg_writes, sb.results, sb.mismatches, sb.due_pixels.size());
    if (sb.mismatches == 0 && sb.due_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd60_000_000);
    $display("run timed out");
    $display("TEST FAILED");
    $finish;
  end

endmodule
